// File: design/lcgrr_pkg.sv
// ----------------------------------------------------------------------------
// lcgrr_pkg: shared types and constants for the LCG random unit
// Operation codes, generator constants, the sequencer state type and the adder operand select.
// ----------------------------------------------------------------------------
package lcgrr_pkg;

    localparam int unsigned DATA_W = 32;

    // operation codes carried by the op field
    localparam logic [1:0] OP_RESET  = 2'd0;
    localparam logic [1:0] OP_FRAC   = 2'd1;
    localparam logic [1:0] OP_RANGE  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // generator constants, modulo 2^32
    localparam logic [DATA_W-1:0] LCG_MUL = 32'd1664525;
    localparam logic [DATA_W-1:0] LCG_ADD = 32'd1013904223;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_INC,
        ST_DIV,
        ST_OFFSET,
        ST_DONE
    } state_t;

    // operand selection for the shared adder
    typedef enum logic [2:0] {
        ADD_CMP,
        ADD_SPAN,
        ADD_INC,
        ADD_DIV,
        ADD_OFFSET
    } add_sel_t;

endpackage

// File: design/lcg_random_with_range_unit.sv
// ----------------------------------------------------------------------------
// lcg_random_with_range_unit: 32-bit linear congruential random source
// Advances seed' = 1664525 * seed + 1013904223 and returns the new seed as a
// Q0.32 fraction, plus (seed' mod span) + range_low for ranged draws.
// ----------------------------------------------------------------------------
// One item is worked at a time; in_stall is high from the cycle after a draw
// beat is taken until the unit is back in idle. A seed reset (op 0) or an
// unused op gives no result and leaves the unit in idle. A fraction draw
// steps through accept, multiply, increment and result load. A ranged draw
// adds the remainder by the run-time span after the increment, a 32-step
// restoring loop on the one shared 33-bit adder, which also does the bound
// compare, the span, the increment and the final offset. A ranged draw with
// range_low not below range_high returns range_error with zero data and the
// seed untouched. The result load waits while the previous result beat is
// still stalled at the output.
module lcg_random_with_range_unit
    import lcgrr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               op,
    input  logic signed [DATA_W-1:0] range_low,
    input  logic signed [DATA_W-1:0] range_high,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [DATA_W-1:0]        fraction,
    output logic signed [DATA_W-1:0] number,
    output logic                     range_error
);

    localparam int unsigned CNT_W = $clog2(DATA_W);

    state_t              state_reg, state_next;
    logic [DATA_W-1:0]   seed_reg, seed_next;
    logic [DATA_W-1:0]   lo_reg, lo_next;
    logic [DATA_W-1:0]   hi_reg, hi_next;
    logic [DATA_W-1:0]   span_reg, span_next;
    logic [DATA_W-1:0]   prod_reg, prod_next;
    logic [DATA_W-1:0]   dvd_reg, dvd_next;
    logic [DATA_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                ranged_reg, ranged_next;
    logic                err_reg, err_next;

    logic                out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]   fraction_reg, fraction_next;
    logic [DATA_W-1:0]   number_reg, number_next;
    logic                range_error_reg, range_error_next;

    add_sel_t            add_sel;
    logic [DATA_W:0]     add_a, add_b;
    logic                add_cin;
    logic [DATA_W+1:0]   add_sum;
    logic [DATA_W:0]     rem_shift;
    logic [DATA_W-1:0]   mul_full;
    logic                in_beat;
    logic                slot_free;
    logic                range_ok;

    assign in_beat   = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign rem_shift = {rem_reg, dvd_reg[DATA_W-1]};
    assign mul_full  = seed_reg * LCG_MUL;

    // shared adder
    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
        case (add_sel)
            ADD_CMP:
            begin
                add_a   = {range_low[DATA_W-1], range_low};
                add_b   = ~{range_high[DATA_W-1], range_high};
                add_cin = 1'b1;
            end
            ADD_SPAN:
            begin
                add_a   = {1'b0, hi_reg};
                add_b   = ~{1'b0, lo_reg};
                add_cin = 1'b1;
            end
            ADD_INC:
            begin
                add_a = {1'b0, prod_reg};
                add_b = {1'b0, LCG_ADD};
            end
            ADD_DIV:
            begin
                add_a   = rem_shift;
                add_b   = ~{1'b0, span_reg};
                add_cin = 1'b1;
            end
            ADD_OFFSET:
            begin
                add_a = {1'b0, rem_reg};
                add_b = {1'b0, lo_reg};
            end
            default:
            begin
                add_a = '0;
            end
        endcase
        add_sum = {1'b0, add_a} + {1'b0, add_b} + {{(DATA_W+1){1'b0}}, add_cin};
    end

    // signed low < high shows as a negative sign-extended difference
    assign range_ok = add_sum[DATA_W];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (op)
                        OP_FRAC:  state_next = ST_MUL;
                        OP_RANGE: state_next = range_ok ? ST_MUL : ST_DONE;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MUL:    state_next = ST_INC;
            ST_INC:    state_next = ranged_reg ? ST_DIV : ST_DONE;
            ST_DIV:    state_next = (cnt_reg == '0) ? ST_OFFSET : ST_DIV;
            ST_OFFSET: state_next = ST_DONE;
            ST_DONE:   state_next = slot_free ? ST_IDLE : ST_DONE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall = 1'b1;
        add_sel  = ADD_CMP;
        case (state_reg)
            ST_IDLE:   in_stall = 1'b0;
            ST_MUL:    add_sel  = ADD_SPAN;
            ST_INC:    add_sel  = ADD_INC;
            ST_DIV:    add_sel  = ADD_DIV;
            ST_OFFSET: add_sel  = ADD_OFFSET;
            default:   add_sel  = ADD_CMP;
        endcase
    end

    // datapath updates
    always_comb
    begin
        seed_next        = seed_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        span_next        = span_reg;
        prod_next        = prod_reg;
        dvd_next         = dvd_reg;
        rem_next         = rem_reg;
        cnt_next         = cnt_reg;
        ranged_next      = ranged_reg;
        err_next         = err_reg;
        out_valid_next   = out_valid_reg && out_stall;
        fraction_next    = fraction_reg;
        number_next      = number_reg;
        range_error_next = range_error_reg;
        case (state_reg)
            ST_IDLE:
            begin
                // latch the beat
                if (in_beat)
                begin
                    lo_next     = range_low;
                    hi_next     = range_high;
                    ranged_next = (op == OP_RANGE);
                    err_next    = (op == OP_RANGE) && !range_ok;
                    if (op == OP_RESET)
                    begin
                        seed_next = '0;
                    end
                end
            end
            ST_MUL:
            begin
                prod_next = mul_full;
                span_next = add_sum[DATA_W-1:0];
            end
            ST_INC:
            begin
                // advance the seed and load the remainder loop
                seed_next = add_sum[DATA_W-1:0];
                dvd_next  = add_sum[DATA_W-1:0];
                rem_next  = '0;
                cnt_next  = CNT_W'(DATA_W - 1);
            end
            ST_DIV:
            begin
                // one restoring step: keep the difference when no borrow
                rem_next = add_sum[DATA_W+1] ? add_sum[DATA_W-1:0]
                                             : rem_shift[DATA_W-1:0];
                dvd_next = {dvd_reg[DATA_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
            end
            ST_OFFSET:
            begin
                rem_next = add_sum[DATA_W-1:0];
            end
            ST_DONE:
            begin
                // drop the result into the output register once it is free
                if (slot_free)
                begin
                    out_valid_next   = 1'b1;
                    range_error_next = err_reg;
                    fraction_next    = err_reg ? '0 : seed_reg;
                    number_next      = (err_reg || !ranged_reg) ? '0 : rem_reg;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && out_stall;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seed_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seed_reg      <= seed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        span_reg        <= span_next;
        prod_reg        <= prod_next;
        dvd_reg         <= dvd_next;
        rem_reg         <= rem_next;
        cnt_reg         <= cnt_next;
        ranged_reg      <= ranged_next;
        err_reg         <= err_next;
        fraction_reg    <= fraction_next;
        number_reg      <= number_next;
        range_error_reg <= range_error_next;
    end

    assign out_valid   = out_valid_reg;
    assign fraction    = fraction_reg;
    assign number      = number_reg;
    assign range_error = range_error_reg;

    // a draw beat keeps the input stalled on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && (op == OP_FRAC || op == OP_RANGE)) |=> in_stall)
        else $error("input not stalled after a draw beat");

    // an error result carries zero data
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && range_error) |-> (fraction == '0 && number == '0))
        else $error("error result with nonzero data");

    // the partial remainder stays below the span
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < span_reg))
        else $error("remainder not below span");

    // a seed reset beat clears the seed
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && op == OP_RESET) |=> (seed_reg == '0))
        else $error("seed not cleared by reset beat");

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for lcg_random_with_range_unit
// Drives seed resets, fraction draws and ranged draws through the input
// handshake with bursty pacing and checks every result beat against a pinned
// draw or a bit-accurate predictor of the 32-bit generator held in the bench.
// ----------------------------------------------------------------------------
module tb;
    import lcgrr_pkg::*;

    typedef logic signed [DATA_W-1:0] sword_t;

    typedef struct packed {
        logic [DATA_W-1:0] fraction;
        sword_t            number;
        logic              range_error;
    } draw_t;

    // a draw typed in by hand overrides the predicted one
    typedef struct packed {
        bit    fixed;
        draw_t value;
    } pinned_t;

    typedef struct packed {
        logic [1:0] code;
        sword_t     lo;
        sword_t     hi;
        pinned_t    pin;
    } stim_row_t;

    localparam sword_t SMIN = 32'sh8000_0000;
    localparam sword_t SMAX = 32'sh7FFF_FFFF;
    localparam int RANDOM_ITEMS = 700;
    localparam int PAUSE_AT = 350;
    localparam int HOLD_AFTER = 120;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam pinned_t PREDICT = '{1'b0, '0};
    localparam pinned_t BAD_RANGE = '{1'b1, '{32'd0, 32'sd0, 1'b1}};

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] op;
    sword_t     range_low;
    sword_t     range_high;
    logic       out_valid;
    logic       out_stall;
    logic [DATA_W-1:0] fraction;
    sword_t     number;
    logic       range_error;

    draw_t     pending_draws [$];
    pinned_t   pinned_draws [$];
    stim_row_t directed_rows [$];
    logic [DATA_W-1:0] model_seed;
    int failures;
    int results_seen;
    int idle_cycles;
    int burst_left;
    bit long_hold_done;

    lcg_random_with_range_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .range_low   (range_low),
        .range_high  (range_high),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .fraction    (fraction),
        .number      (number),
        .range_error (range_error)
    );

    // free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // advance the generator for one item; return 1 when the item gives a draw
    function automatic bit next_draw(input logic [1:0] code, input sword_t lo,
                                     input sword_t hi, output draw_t res);
        logic [DATA_W-1:0] span;
        res = '0;
        case (code)
            OP_RESET:
            begin
                model_seed = '0;
                return 1'b0;
            end
            OP_FRAC:
            begin
                model_seed = model_seed * LCG_MUL + LCG_ADD;
                res.fraction = model_seed;
                return 1'b1;
            end
            OP_RANGE:
            begin
                // empty or reversed range: flag it and keep the seed
                if (lo >= hi)
                begin
                    res.range_error = 1'b1;
                    return 1'b1;
                end
                model_seed = model_seed * LCG_MUL + LCG_ADD;
                span = hi - lo;
                res.fraction = model_seed;
                res.number = (model_seed % span) + lo;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                   input logic [DATA_W-1:0] got);
        $display("ERROR: draw %0d %s: expected %h, got %h", results_seen, what, want, got);
        failures++;
    endtask

    // check result beats, then predict accepted input beats
    always @(posedge clk)
    begin : monitor
        draw_t   want;
        draw_t   got;
        pinned_t pin;
        bit      gives;
        bit      moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                got = '{fraction, number, range_error};
                if (pending_draws.size() == 0)
                    report_mismatch("result with nothing pending", '0, got.fraction);
                else
                begin
                    want = pending_draws.pop_front();
                    if (got.fraction !== want.fraction)
                        report_mismatch("fraction", want.fraction, got.fraction);
                    if (got.number !== want.number)
                        report_mismatch("number", want.number, got.number);
                    if (got.range_error !== want.range_error)
                        report_mismatch("range_error", DATA_W'(want.range_error),
                                        DATA_W'(got.range_error));
                end
                results_seen++;
            end
            if (in_valid && !in_stall)
            begin
                moved = 1'b1;
                pin = pinned_draws.pop_front();
                gives = next_draw(op, range_low, range_high, want);
                if (pin.fixed)
                    want = pin.value;
                if (gives)
                    pending_draws.push_back(want);
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    // end the run when the handshakes stop moving
    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("ERROR: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // receiver: one long hold-off, otherwise stall in runs of varying density
    initial
    begin : receiver
        int run;
        int mode;
        out_stall = 1'b0;
        wait (rst_n);
        forever
        begin
            if (!long_hold_done && results_seen >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            mode = $urandom_range(0, 3);
            run = $urandom_range(1, 40);
            repeat (run)
            begin
                case (mode)
                    0: out_stall = 1'b0;
                    1: out_stall = ($urandom_range(0, 1) == 1);
                    2: out_stall = ($urandom_range(0, 3) != 0);
                    default: out_stall = ($urandom_range(0, 7) == 0);
                endcase
                @(negedge clk);
            end
        end
    end

    // offer one beat at a falling edge and hold it until taken
    task automatic send_beat(input stim_row_t row);
        pinned_draws.push_back(row.pin);
        in_valid = 1'b1;
        op = row.code;
        range_low = row.lo;
        range_high = row.hi;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // close the burst when it runs out and idle for a random gap
    task automatic pace_sender();
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
    endtask

    // random item: mostly valid draws, some resets, bad ranges and unused codes
    function automatic stim_row_t make_random_beat();
        stim_row_t row;
        sword_t    a;
        sword_t    b;
        logic [DATA_W-1:0] span;
        int pick;
        row.pin = PREDICT;
        row.lo = $urandom;
        row.hi = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            row.code = OP_RESET;
        else if (pick < 11)
            row.code = OP_UNUSED;
        else if (pick < 45)
            row.code = OP_FRAC;
        else
        begin
            row.code = OP_RANGE;
            a = $urandom;
            b = $urandom;
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    // reversed or empty range
                    if ($urandom_range(0, 3) == 0)
                        b = a;
                    row.lo = (a >= b) ? a : b;
                    row.hi = (a >= b) ? b : a;
                end
                2, 3, 4:
                begin
                    span = $urandom_range(1, 1000);
                    row.lo = a;
                    row.hi = a + span;
                    if (row.hi <= row.lo)
                    begin
                        row.hi = SMAX;
                        row.lo = SMAX - span;
                    end
                end
                5:
                begin
                    span = 32'd1 << $urandom_range(0, 30);
                    row.lo = a;
                    row.hi = a + span;
                    if (row.hi <= row.lo)
                    begin
                        row.hi = SMAX;
                        row.lo = SMAX - span;
                    end
                end
                default:
                begin
                    if (a == b)
                        b = a ^ 32'sd1;
                    row.lo = (a < b) ? a : b;
                    row.hi = (a < b) ? b : a;
                end
            endcase
        end
        return row;
    endfunction

    // reset, directed table, random items, drain
    initial
    begin : stimulus
        stim_row_t row;
        int counted;
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_RESET;
        range_low = '0;
        range_high = '0;
        model_seed = '0;
        failures = 0;
        results_seen = 0;
        idle_cycles = 0;
        burst_left = 4;
        long_hold_done = 1'b0;

        // first draws from a zero seed, then back to zero
        directed_rows.push_back('{OP_FRAC, 32'sd0, 32'sd0,
                                  '{1'b1, '{32'd1013904223, 32'sd0, 1'b0}}});
        directed_rows.push_back('{OP_FRAC, SMAX, SMIN,
                                  '{1'b1, '{32'd1196435762, 32'sd0, 1'b0}}});
        directed_rows.push_back('{OP_RESET, SMIN, SMAX, PREDICT});
        directed_rows.push_back('{OP_FRAC, SMIN, SMAX,
                                  '{1'b1, '{32'd1013904223, 32'sd0, 1'b0}}});
        directed_rows.push_back('{OP_UNUSED, SMIN, SMAX, PREDICT});
        // unit span, full span and spans at the signed extremes
        directed_rows.push_back('{OP_RANGE, 32'sd0, 32'sd1, PREDICT});
        directed_rows.push_back('{OP_RANGE, SMIN, SMAX, PREDICT});
        directed_rows.push_back('{OP_RANGE, SMIN, SMIN + 32'sd1, PREDICT});
        directed_rows.push_back('{OP_RANGE, SMAX - 32'sd1, SMAX, PREDICT});
        directed_rows.push_back('{OP_RANGE, -32'sd1, 32'sd0, PREDICT});
        directed_rows.push_back('{OP_RANGE, -32'sd100, 32'sd100, PREDICT});
        directed_rows.push_back('{OP_RANGE, 32'sd0, SMAX, PREDICT});
        directed_rows.push_back('{OP_RANGE, SMIN, 32'sd0, PREDICT});
        // empty and reversed ranges leave the seed alone
        directed_rows.push_back('{OP_RANGE, 32'sd5, 32'sd5, BAD_RANGE});
        directed_rows.push_back('{OP_RANGE, SMAX, SMIN, BAD_RANGE});
        directed_rows.push_back('{OP_RANGE, 32'sd0, -32'sd1, BAD_RANGE});
        directed_rows.push_back('{OP_RANGE, SMIN, SMIN, BAD_RANGE});
        directed_rows.push_back('{OP_RANGE, SMAX, SMAX, BAD_RANGE});
        directed_rows.push_back('{OP_FRAC, 32'sd0, 32'sd0, PREDICT});
        // first seed after a reset is odd, so a span of two gives one
        directed_rows.push_back('{OP_RESET, SMAX, SMAX, PREDICT});
        directed_rows.push_back('{OP_RANGE, 32'sd0, 32'sd2,
                                  '{1'b1, '{32'd1013904223, 32'sd1, 1'b0}}});
        directed_rows.push_back('{OP_UNUSED, -32'sd1, -32'sd1, PREDICT});
        directed_rows.push_back('{OP_RANGE, 32'sh5555_5555, 32'sh7AAA_AAAA, PREDICT});

        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            send_beat(directed_rows[i]);
            pace_sender();
        end

        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            // hold off once until every draw is back
            if (counted == PAUSE_AT)
            begin
                in_valid = 1'b0;
                wait (pending_draws.size() == 0);
                @(negedge clk);
            end
            row = make_random_beat();
            send_beat(row);
            if (row.code != OP_UNUSED)
                counted++;
            pace_sender();
        end

        // drop valid and drain
        in_valid = 1'b0;
        wait (pending_draws.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: lcg_random_with_range_unit.f
design/lcgrr_pkg.sv
design/lcg_random_with_range_unit.sv
test/tb.sv
